// File: rtl/core/rnf_pkg.sv
// Shared types and constants for the RTP NAL fragmenter.
`timescale 1ns / 1ps

package rnf_pkg;

  // Configuration register indexes
  localparam logic CFG_IDX_CODEC         = 1'b0;
  localparam logic CFG_IDX_PAYLOAD_LIMIT = 1'b1;

  // FU type codes and header masks
  localparam logic [7:0] H264_FU_TYPE   = 8'd28;
  localparam logic [7:0] H265_FU_TYPE   = 8'd49;
  localparam logic [7:0] H264_NRI_MASK  = 8'hE0;
  localparam logic [7:0] H265_KEEP_MASK = 8'h81;

  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned SHORT_NAL   = 4;
  localparam int unsigned HEAD_H264   = 2;
  localparam int unsigned HEAD_H265   = 3;
  localparam int unsigned PAYLOAD_LIMIT_RESET = 1400;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       stop;
    logic       marker;
    logic       hdr;
    logic       last;
  } result_t;

endpackage

// File: rtl/core/rtp_nal_fragmenter.sv
// RTP payload packetizer that splits H.264 / H.265 NAL units into FU fragments.
// A byte's first result is registered and shown in the cycle after its acceptance.
// Throughput: one NAL byte per cycle while out_ready_i is high; a byte that opens a
// fragment gives 3 (H.264) or 4 (H.265) results and holds the input until the last
// is taken. The four-entry result register drains one transaction per ready cycle.
// Reset: asynchronous, clears all but res_q; codec H.264 and payload limit 1400.
`timescale 1ns / 1ps

module rtp_nal_fragmenter #(
  parameter int unsigned LENGTH_BITS  = 24,
  parameter int unsigned PAYLOAD_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [PAYLOAD_BITS-1:0] cfg_data_i,
  // NAL byte input
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              nal_byte_i,
  input  logic                    nal_first_i,
  input  logic [LENGTH_BITS-1:0]  nal_length_i,
  input  logic                    au_end_i,
  // payload output
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [7:0]              out_byte_o,
  output logic                    packet_start_o,
  output logic                    packet_end_o,
  output logic                    rtp_marker_o,
  output logic                    header_byte_o,
  output logic                    run_last_o
);

  import rnf_pkg::*;

  localparam int unsigned W  = (LENGTH_BITS > PAYLOAD_BITS) ? LENGTH_BITS : PAYLOAD_BITS;
  localparam int unsigned LB = LENGTH_BITS;
  localparam int unsigned PB = PAYLOAD_BITS;
  localparam int unsigned IW = $clog2(MAX_RESULTS);

  // configuration
  logic          codec_h265_q;
  logic [PB-1:0] payload_limit_q;

  // packetizer state
  logic [LB-1:0] pos_q, pos_d;
  logic [PB-1:0] fbl_q, fbl_d;
  logic          frag_q, frag_d;
  logic          skip_q, skip_d;
  logic [7:0]    fu_ind_q, fu_ind_d;
  logic [7:0]    second_q, second_d;
  logic [5:0]    orig_q, orig_d;
  logic          ffrag_q, ffrag_d;

  // result register
  result_t       res_q [MAX_RESULTS];
  result_t       slot  [MAX_RESULTS];
  logic          have_q;
  logic [IW-1:0] idx_q;
  logic [IW-1:0] lastidx_q;
  logic          have_new;
  logic [IW-1:0] lastidx_new;

  // step logic
  logic          in_fire, out_fire, drain_last;
  logic [LB-1:0] pos_base, pos_inc, left;
  logic [PB-1:0] fbl_base, head, chunk, body, cur;
  logic          ff_base, skip_base, frag_base, short_nal, drop, last_frag;
  logic [7:0]    fuh;

  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_o && out_ready_i;
  assign drain_last = idx_q == lastidx_q;
  assign in_ready_o = !have_q || (out_ready_i && drain_last);

  always_comb begin
    short_nal = W'(nal_length_i) < W'(SHORT_NAL);
    pos_base  = nal_first_i ? '0 : pos_q;
    fbl_base  = nal_first_i ? '0 : fbl_q;
    ff_base   = nal_first_i ? 1'b1 : ffrag_q;
    skip_base = nal_first_i ? short_nal : skip_q;
    frag_base = nal_first_i ? (!short_nal && (W'(nal_length_i) > W'(payload_limit_q)))
                            : frag_q;
    drop      = skip_base || (pos_base >= nal_length_i);
    pos_inc   = pos_base + LB'(1);
    left      = nal_length_i - pos_base;
    head      = codec_h265_q ? PB'(HEAD_H265) : PB'(HEAD_H264);
    chunk     = (payload_limit_q > head) ? (payload_limit_q - head) : PB'(1);
    body      = (W'(left) < W'(chunk)) ? PB'(left) : chunk;
    last_frag = W'(body) == W'(left);
    fuh       = {ff_base, last_frag, orig_q};

    pos_d    = pos_base;
    fbl_d    = fbl_base;
    ffrag_d  = ff_base;
    skip_d   = skip_base;
    frag_d   = frag_base;
    fu_ind_d = fu_ind_q;
    second_d = second_q;
    orig_d   = orig_q;
    cur      = fbl_base;

    have_new    = 1'b0;
    lastidx_new = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      slot[i] = '0;
    end

    if (!drop) begin
      pos_d = pos_inc;
      if (!frag_base) begin
        have_new = 1'b1;
        slot[0]  = '{data: nal_byte_i, start: pos_base == '0, stop: pos_inc == nal_length_i,
                     marker: au_end_i, hdr: 1'b0, last: 1'b1};
      end else if (pos_base == '0) begin
        // latch the original header; it is not re-sent
        if (codec_h265_q) begin
          fu_ind_d = (H265_FU_TYPE << 1) | (nal_byte_i & H265_KEEP_MASK);
          orig_d   = nal_byte_i[6:1];
        end else begin
          fu_ind_d = H264_FU_TYPE | (nal_byte_i & H264_NRI_MASK);
          orig_d   = {1'b0, nal_byte_i[4:0]};
        end
      end else if (codec_h265_q && pos_base == LB'(1)) begin
        second_d = nal_byte_i;
      end else begin
        have_new = 1'b1;
        if (fbl_base == '0) begin
          // open a new fragment: FU header bytes go ahead of the data byte
          cur     = body;
          ffrag_d = 1'b0;
          slot[0] = '{data: fu_ind_q, start: 1'b1, stop: 1'b0,
                      marker: au_end_i && last_frag, hdr: 1'b1, last: 1'b0};
          if (codec_h265_q) begin
            slot[1] = '{data: second_q, start: 1'b0, stop: 1'b0,
                        marker: au_end_i && last_frag, hdr: 1'b1, last: 1'b0};
            slot[2] = '{data: fuh, start: 1'b0, stop: 1'b0,
                        marker: au_end_i && last_frag, hdr: 1'b1, last: 1'b0};
            lastidx_new = IW'(3);
          end else begin
            slot[1] = '{data: fuh, start: 1'b0, stop: 1'b0,
                        marker: au_end_i && last_frag, hdr: 1'b1, last: 1'b0};
            lastidx_new = IW'(2);
          end
        end
        fbl_d = cur - PB'(1);
        slot[lastidx_new] = '{data: nal_byte_i, start: 1'b0, stop: cur == PB'(1),
                              marker: au_end_i && (W'(left) == W'(cur)),
                              hdr: 1'b0, last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_h265_q    <= 1'b0;
      payload_limit_q <= PB'(PAYLOAD_LIMIT_RESET);
      pos_q           <= '0;
      fbl_q           <= '0;
      frag_q          <= 1'b0;
      skip_q          <= 1'b0;
      fu_ind_q        <= '0;
      second_q        <= '0;
      orig_q          <= '0;
      ffrag_q         <= 1'b1;
      have_q          <= 1'b0;
      idx_q           <= '0;
      lastidx_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_IDX_CODEC:         codec_h265_q    <= cfg_data_i[0];
          CFG_IDX_PAYLOAD_LIMIT: payload_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_fire) begin
        pos_q     <= pos_d;
        fbl_q     <= fbl_d;
        frag_q    <= frag_d;
        skip_q    <= skip_d;
        fu_ind_q  <= fu_ind_d;
        second_q  <= second_d;
        orig_q    <= orig_d;
        ffrag_q   <= ffrag_d;
        have_q    <= have_new;
        idx_q     <= '0;
        lastidx_q <= lastidx_new;
      end else if (out_fire) begin
        // advance through the held results, drop the set after its last
        if (drain_last) begin
          have_q <= 1'b0;
        end else begin
          idx_q <= idx_q + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        res_q[i] <= slot[i];
      end
    end
  end

  assign out_valid_o    = have_q;
  assign out_byte_o     = res_q[idx_q].data;
  assign packet_start_o = res_q[idx_q].start;
  assign packet_end_o   = res_q[idx_q].stop;
  assign rtp_marker_o   = res_q[idx_q].marker;
  assign header_byte_o  = res_q[idx_q].hdr;
  assign run_last_o     = res_q[idx_q].last;

`ifndef SYNTHESIS
  a_hold_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> !in_ready_o)
    else $error("input taken while results of the previous byte are pending");

  a_run_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !run_last_o |=> out_valid_o && !packet_start_o)
    else $error("result run broken before its last transaction");

  a_header_not_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && header_byte_o |-> !packet_end_o && !run_last_o)
    else $error("FU header byte closes a packet or a run");

  a_run_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (run_last_o == (idx_q == lastidx_q)))
    else $error("run_last disagrees with the result index");
`endif

endmodule
